[sv/esd_pkg.sv]
// Shared types and constants for the elevator stop dispatcher.
// No dependencies; every other file refers to it by scoped names.
package esd_pkg;

    localparam int FLOOR_W      = 4;
    localparam int RESULT_LIMIT = 8;

    typedef enum logic [1:0] {
        MODE_REQUEST,
        MODE_MOVE,
        MODE_FAIL,
        MODE_RESET
    } esd_mode_t;

    typedef enum logic [3:0] {
        ST_ADDED,
        ST_HERE,
        ST_DUP,
        ST_INVALID,
        ST_FAILED,
        ST_PASSING,
        ST_ARRIVED,
        ST_IDLE,
        ST_FAILSET,
        ST_RESET
    } esd_status_t;

    typedef enum logic [1:0] {
        DIR_IDLE,
        DIR_UP,
        DIR_DOWN
    } esd_dir_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TRAVEL
    } esd_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic step;
    } esd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic can_emit;
        logic trip_start;
        logic arrive;
    } esd_stat_t;

endpackage

[sv/esd_ctrl.sv]
// Sequencing state machine of the elevator stop dispatcher.
// Depends on esd_pkg for the state enum and the command/status structs.
module esd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output esd_pkg::esd_cmd_t cmd,
    input  esd_pkg::esd_stat_t stat
);

    esd_pkg::esd_state_t state_reg;
    esd_pkg::esd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= esd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            esd_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = esd_pkg::S_EXEC;
                end
            end
            esd_pkg::S_EXEC:
            begin
                if (stat.can_emit)
                begin
                    state_next = stat.trip_start ? esd_pkg::S_TRAVEL : esd_pkg::S_IDLE;
                end
            end
            esd_pkg::S_TRAVEL:
            begin
                if (stat.can_emit && stat.arrive)
                begin
                    state_next = esd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = esd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == esd_pkg::S_IDLE);
        cmd.load = (state_reg == esd_pkg::S_IDLE) && in_valid;
        cmd.exec = (state_reg == esd_pkg::S_EXEC) && stat.can_emit;
        cmd.step = (state_reg == esd_pkg::S_TRAVEL) && stat.can_emit;
    end

endmodule

[sv/esd_datapath.sv]
// Car state, pending stop sets, command decode and result register.
// Depends on esd_pkg; driven by commands from esd_ctrl.
module esd_datapath
#(
    parameter int NUM_FLOORS = 9
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  esd_pkg::esd_cmd_t             cmd,
    output esd_pkg::esd_stat_t            stat,
    input  logic [1:0]                    mode,
    input  logic [esd_pkg::FLOOR_W-1:0]   floor,
    input  logic                          is_pickup,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3:0]                    status,
    output logic [esd_pkg::FLOOR_W-1:0]   car_floor,
    output logic [1:0]                    travel_dir,
    output logic [esd_pkg::FLOOR_W-1:0]   next_stop,
    output logic                          last
);

    localparam int SET_W = NUM_FLOORS + 1;
    localparam int FW    = esd_pkg::FLOOR_W;

    // lowest set floor above 0, or 0
    function automatic logic [FW-1:0] lowest_floor(input logic [15:0] s);
        logic [FW-1:0] r;
        r = '0;
        for (int f = 15; f >= 1; f--)
        begin
            if (s[f])
            begin
                r = FW'(f);
            end
        end
        return r;
    endfunction

    function automatic logic [FW-1:0] highest_floor(input logic [15:0] s);
        logic [FW-1:0] r;
        r = '0;
        for (int f = 1; f <= 15; f++)
        begin
            if (s[f])
            begin
                r = FW'(f);
            end
        end
        return r;
    endfunction

    function automatic logic [FW-1:0] pick_target(input logic [SET_W-1:0] drop_s,
                                                  input logic [SET_W-1:0] pick_s);
        logic [FW-1:0] r;
        if (|drop_s)
        begin
            r = lowest_floor(16'(drop_s));
        end
        else
        begin
            r = highest_floor(16'(pick_s));
        end
        return r;
    endfunction

    // latched command
    esd_pkg::esd_mode_t  mode_reg;
    logic [FW-1:0]       floor_reg;
    logic                pick_reg;

    // car state
    logic [FW-1:0]       car_reg,  car_next;
    esd_pkg::esd_dir_t   dir_reg,  dir_next;
    logic                failed_reg, failed_next;
    logic [SET_W-1:0]    pickset_reg, pickset_next;
    logic [SET_W-1:0]    dropset_reg, dropset_next;
    logic [FW-1:0]       target_reg, target_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    esd_pkg::esd_status_t out_status_reg;
    logic [FW-1:0]       out_car_reg;
    esd_pkg::esd_dir_t   out_dir_reg;
    logic [FW-1:0]       out_stop_reg;
    logic                out_last_reg;

    logic                emit;
    esd_pkg::esd_status_t res_status;
    logic                res_last;
    logic                res_use_target;
    logic                res_zero;
    logic [FW-1:0]       cur_target;
    logic [FW-1:0]       new_target;
    logic [FW-1:0]       trip_span;
    logic [SET_W-1:0]    floor_mask;
    logic [SET_W-1:0]    tgt_mask;
    logic                any_pending;
    logic                floor_bad;

    assign cur_target  = pick_target(dropset_reg, pickset_reg);
    assign new_target  = pick_target(dropset_next, pickset_next);
    assign trip_span   = (target_reg > car_reg) ? (target_reg - car_reg) : (car_reg - target_reg);
    assign floor_mask  = SET_W'(1) << floor_reg;
    assign tgt_mask    = SET_W'(1) << target_reg;
    assign any_pending = (|pickset_reg) || (|dropset_reg);
    assign floor_bad   = (floor_reg == '0) || (floor_reg > FW'(NUM_FLOORS));

    always_comb
    begin
        stat.can_emit   = !out_valid_reg || out_ready;
        stat.trip_start = (mode_reg == esd_pkg::MODE_MOVE) && !failed_reg && any_pending;
        stat.arrive     = (trip_span <= FW'(1));
    end

    always_comb
    begin
        car_next       = car_reg;
        dir_next       = dir_reg;
        failed_next    = failed_reg;
        pickset_next   = pickset_reg;
        dropset_next   = dropset_reg;
        target_next    = target_reg;
        emit           = 1'b0;
        res_status     = esd_pkg::ST_IDLE;
        res_last       = 1'b1;
        res_use_target = 1'b0;
        res_zero       = 1'b0;

        if (cmd.exec)
        begin
            unique case (mode_reg)
                esd_pkg::MODE_REQUEST:
                begin
                    emit = 1'b1;
                    priority if (failed_reg)
                    begin
                        res_status = esd_pkg::ST_FAILED;
                    end
                    else if (floor_bad)
                    begin
                        res_status = esd_pkg::ST_INVALID;
                    end
                    else if (floor_reg == car_reg)
                    begin
                        res_status = esd_pkg::ST_HERE;
                    end
                    else if (pick_reg)
                    begin
                        if (|(pickset_reg & floor_mask))
                        begin
                            res_status = esd_pkg::ST_DUP;
                        end
                        else
                        begin
                            pickset_next = pickset_reg | floor_mask;
                            res_status   = esd_pkg::ST_ADDED;
                        end
                    end
                    else
                    begin
                        if (|(dropset_reg & floor_mask))
                        begin
                            res_status = esd_pkg::ST_DUP;
                        end
                        else
                        begin
                            dropset_next = dropset_reg | floor_mask;
                            res_status   = esd_pkg::ST_ADDED;
                        end
                    end
                end
                esd_pkg::MODE_MOVE:
                begin
                    priority if (failed_reg)
                    begin
                        emit       = 1'b1;
                        res_status = esd_pkg::ST_FAILED;
                    end
                    else if (!any_pending)
                    begin
                        emit       = 1'b1;
                        res_status = esd_pkg::ST_IDLE;
                        res_zero   = 1'b1;
                    end
                    else
                    begin
                        // start of trip: latch target and direction, no result yet
                        target_next = cur_target;
                        if (cur_target > car_reg)
                        begin
                            dir_next = esd_pkg::DIR_UP;
                        end
                        else if (cur_target < car_reg)
                        begin
                            dir_next = esd_pkg::DIR_DOWN;
                        end
                    end
                end
                esd_pkg::MODE_FAIL:
                begin
                    emit        = 1'b1;
                    failed_next = 1'b1;
                    res_status  = esd_pkg::ST_FAILSET;
                end
                esd_pkg::MODE_RESET:
                begin
                    emit         = 1'b1;
                    car_next     = FW'(1);
                    dir_next     = esd_pkg::DIR_IDLE;
                    failed_next  = 1'b0;
                    pickset_next = '0;
                    dropset_next = '0;
                    res_status   = esd_pkg::ST_RESET;
                    res_zero     = 1'b1;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
        else if (cmd.step)
        begin
            if (trip_span <= FW'(1))
            begin
                // arrive: drop-off entry wins over pick-up entry
                car_next = target_reg;
                if (|(dropset_reg & tgt_mask))
                begin
                    dropset_next = dropset_reg & ~tgt_mask;
                end
                else
                begin
                    pickset_next = pickset_reg & ~tgt_mask;
                end
                if (!(|dropset_next) && !(|pickset_next))
                begin
                    dir_next = esd_pkg::DIR_IDLE;
                end
                emit       = 1'b1;
                res_status = esd_pkg::ST_ARRIVED;
            end
            else
            begin
                car_next = (dir_reg == esd_pkg::DIR_UP) ? car_reg + FW'(1) : car_reg - FW'(1);
                // only the final floors of a long trip are reported
                emit           = (trip_span <= FW'(esd_pkg::RESULT_LIMIT));
                res_status     = esd_pkg::ST_PASSING;
                res_last       = 1'b0;
                res_use_target = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            car_reg       <= FW'(1);
            dir_reg       <= esd_pkg::DIR_IDLE;
            failed_reg    <= 1'b0;
            pickset_reg   <= '0;
            dropset_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            car_reg       <= car_next;
            dir_reg       <= dir_next;
            failed_reg    <= failed_next;
            pickset_reg   <= pickset_next;
            dropset_reg   <= dropset_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        if (cmd.load)
        begin
            mode_reg  <= esd_pkg::esd_mode_t'(mode);
            floor_reg <= floor;
            pick_reg  <= is_pickup;
        end
        if (emit)
        begin
            out_status_reg <= res_status;
            out_car_reg    <= car_next;
            out_dir_reg    <= dir_next;
            out_last_reg   <= res_last;
            if (res_zero)
            begin
                out_stop_reg <= '0;
            end
            else if (res_use_target)
            begin
                out_stop_reg <= target_reg;
            end
            else
            begin
                out_stop_reg <= new_target;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign car_floor  = out_car_reg;
    assign travel_dir = out_dir_reg;
    assign next_stop  = out_stop_reg;
    assign last       = out_last_reg;

endmodule

[sv/elevator_stop_dispatcher.sv]
// Top level of the elevator stop dispatcher: controller plus datapath.
// Depends on esd_pkg, esd_ctrl and esd_datapath.
//
//   channel  handshake            payload
//   -------  -------------------  -------------------------------------------
//   in       in_valid / in_ready  mode, floor, is_pickup
//   out      out_valid/out_ready  status, car_floor, travel_dir, next_stop, last
//
// One item at a time. A request, failure or reset command is accepted, then
// executed, and gives one result, as does an idle or failed move. A move
// toward a stop adds one stepper step per floor travelled (one when the stop
// is the car's own floor). Results sit in a single output register; while a
// result waits and out_ready is low, the execute and stepper states hold.
// Reset brings the car to floor 1, idle.
module elevator_stop_dispatcher
#(
    parameter int NUM_FLOORS = 9
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  mode,
    input  logic [esd_pkg::FLOOR_W-1:0] floor,
    input  logic                        is_pickup,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [3:0]                  status,
    output logic [esd_pkg::FLOOR_W-1:0] car_floor,
    output logic [1:0]                  travel_dir,
    output logic [esd_pkg::FLOOR_W-1:0] next_stop,
    output logic                        last
);

    esd_pkg::esd_cmd_t  cmd;
    esd_pkg::esd_stat_t stat;

    esd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    esd_datapath
    #(
        .NUM_FLOORS (NUM_FLOORS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .mode       (mode),
        .floor      (floor),
        .is_pickup  (is_pickup),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .car_floor  (car_floor),
        .travel_dir (travel_dir),
        .next_stop  (next_stop),
        .last       (last)
    );

endmodule

[verif/elevator_stop_dispatcher_test.sv]
// Self-checking bench for elevator_stop_dispatcher: directed commands, then random traffic.
// Needs esd_pkg and the dispatcher RTL; a scoreboard class predicts every report.
module elevator_stop_dispatcher_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_FLOORS   = 9;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 2 * (NUM_FLOORS + 2) + 20;
    localparam int PHASE_ITEMS  = 60;

    typedef struct {
        esd_pkg::esd_status_t status;
        logic [3:0]           car_floor;
        esd_pkg::esd_dir_t    travel_dir;
        logic [3:0]           next_stop;
        logic                 last;
    } car_report_t;

    class dispatch_scoreboard;
        car_report_t       pending_reports[$];
        int                errors;
        logic [3:0]        car_at;
        esd_pkg::esd_dir_t heading;
        logic              broken;
        logic [15:0]       pickups;
        logic [15:0]       dropoffs;

        function new();
            errors = 0;
            clear_car();
        endfunction

        function void clear_car();
            car_at   = 4'd1;
            heading  = esd_pkg::DIR_IDLE;
            broken   = 1'b0;
            pickups  = '0;
            dropoffs = '0;
        endfunction

        function logic [3:0] next_target();
            if (dropoffs != 0)
            begin
                for (int f = 1; f <= 15; f++)
                    if (dropoffs[f]) return f[3:0];
            end
            for (int f = 15; f >= 1; f--)
                if (pickups[f]) return f[3:0];
            return 4'd0;
        endfunction

        function void push(esd_pkg::esd_status_t st, logic [3:0] stop,
                           esd_pkg::esd_dir_t d, logic fin);
            car_report_t r;
            r.status     = st;
            r.car_floor  = car_at;
            r.travel_dir = d;
            r.next_stop  = stop;
            r.last       = fin;
            pending_reports.push_back(r);
        endfunction

        function esd_pkg::esd_status_t request_floor(logic [3:0] f, logic pick);
            if (broken) return esd_pkg::ST_FAILED;
            if (f < 1 || f > NUM_FLOORS) return esd_pkg::ST_INVALID;
            if (f == car_at) return esd_pkg::ST_HERE;
            if (pick)
            begin
                if (pickups[f]) return esd_pkg::ST_DUP;
                pickups[f] = 1'b1;
            end
            else
            begin
                if (dropoffs[f]) return esd_pkg::ST_DUP;
                dropoffs[f] = 1'b1;
            end
            return esd_pkg::ST_ADDED;
        endfunction

        function void run_trip();
            logic [3:0] target;
            int         steps;
            int         skip;
            target = next_target();
            steps  = 0;
            if (target > car_at)
            begin
                heading = esd_pkg::DIR_UP;
                steps   = int'(target) - int'(car_at);
            end
            else if (target < car_at)
            begin
                heading = esd_pkg::DIR_DOWN;
                steps   = int'(car_at) - int'(target);
            end
            // only the final RESULT_LIMIT floors of a long trip are reported
            skip = (steps > esd_pkg::RESULT_LIMIT) ? steps - esd_pkg::RESULT_LIMIT : 0;
            for (int i = 1; i < steps; i++)
            begin
                car_at = (heading == esd_pkg::DIR_UP) ? car_at + 4'd1 : car_at - 4'd1;
                if (i > skip) push(esd_pkg::ST_PASSING, target, heading, 1'b0);
            end
            car_at = target;
            if (dropoffs[car_at])
                dropoffs[car_at] = 1'b0;
            else
                pickups[car_at] = 1'b0;
            if (pickups == 0 && dropoffs == 0) heading = esd_pkg::DIR_IDLE;
            push(esd_pkg::ST_ARRIVED, next_target(), heading, 1'b1);
        endfunction

        function void note_command(esd_pkg::esd_mode_t m, logic [3:0] f, logic pick);
            esd_pkg::esd_status_t st;
            case (m)
                esd_pkg::MODE_REQUEST:
                begin
                    st = request_floor(f, pick);
                    push(st, next_target(), heading, 1'b1);
                end
                esd_pkg::MODE_MOVE:
                begin
                    if (broken)
                        push(esd_pkg::ST_FAILED, next_target(), heading, 1'b1);
                    else if (pickups == 0 && dropoffs == 0)
                        push(esd_pkg::ST_IDLE, 4'd0, heading, 1'b1);
                    else
                        run_trip();
                end
                esd_pkg::MODE_FAIL:
                begin
                    broken = 1'b1;
                    push(esd_pkg::ST_FAILSET, next_target(), heading, 1'b1);
                end
                default:
                begin
                    clear_car();
                    push(esd_pkg::ST_RESET, 4'd0, esd_pkg::DIR_IDLE, 1'b1);
                end
            endcase
        endfunction

        function void check_report(logic [3:0] st, logic [3:0] cf, logic [1:0] d,
                                   logic [3:0] ns, logic fin);
            car_report_t e;
            if (pending_reports.size() == 0)
            begin
                $error("report with nothing expected: status %0d floor %0d", st, cf);
                errors++;
                return;
            end
            e = pending_reports.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (cf !== e.car_floor)
            begin
                $error("car_floor: expected %0d, got %0d", e.car_floor, cf);
                errors++;
            end
            if (d !== e.travel_dir)
            begin
                $error("travel_dir: expected %0d, got %0d", e.travel_dir, d);
                errors++;
            end
            if (ns !== e.next_stop)
            begin
                $error("next_stop: expected %0d, got %0d", e.next_stop, ns);
                errors++;
            end
            if (fin !== e.last)
            begin
                $error("last: expected %0d, got %0d", e.last, fin);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_reports.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] mode;
    logic [3:0] floor;
    logic       is_pickup;
    logic       out_valid;
    logic       out_ready;
    logic [3:0] status;
    logic [3:0] car_floor;
    logic [1:0] travel_dir;
    logic [3:0] next_stop;
    logic       last;

    dispatch_scoreboard sb;
    int                 gap_pct;
    int                 stall_pct;
    int                 quiet_cycles;

    elevator_stop_dispatcher #(.NUM_FLOORS(NUM_FLOORS)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .floor      (floor),
        .is_pickup  (is_pickup),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .car_floor  (car_floor),
        .travel_dir (travel_dir),
        .next_stop  (next_stop),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= (int'($urandom_range(99)) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_report(status, car_floor, travel_dir, next_stop, last);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $error("no transfer for %0d cycles", STALL_LIMIT);
            $display("FAIL elevator_stop_dispatcher");
            $finish;
        end
    end

    task automatic send_command(esd_pkg::esd_mode_t m, logic [3:0] f, logic pick);
        while (int'($urandom_range(99)) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        floor     <= f;
        is_pickup <= pick;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_command(m, f, pick);
    endtask

    // hold off the sender until every outstanding report has drained
    task automatic drain_reports();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    task automatic send_random();
        int         r;
        logic [3:0] f;
        logic       p;
        r = int'($urandom_range(99));
        f = 4'($urandom_range(15));
        p = 1'($urandom_range(1));
        // a failed car answers requests and moves with "failed", so bring it back soon
        if (sb.broken && r < 40)
            send_command(esd_pkg::MODE_RESET, f, p);
        else if (r < 55)
        begin
            if ($urandom_range(9) != 0) f = 4'($urandom_range(NUM_FLOORS, 1));
            send_command(esd_pkg::MODE_REQUEST, f, p);
        end
        else if (r < 88)
            send_command(esd_pkg::MODE_MOVE, f, p);
        else if (r < 91)
            send_command(esd_pkg::MODE_FAIL, f, p);
        else
            send_command(esd_pkg::MODE_RESET, f, p);
    endtask

    initial
    begin
        sb           = new();
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = esd_pkg::MODE_REQUEST;
        floor        = '0;
        is_pickup    = 1'b0;
        out_ready    = 1'b0;
        quiet_cycles = 0;
        gap_pct      = 29;
        stall_pct    = 74;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(esd_pkg::MODE_REQUEST, 4'd0, 1'b0);
        send_command(esd_pkg::MODE_REQUEST, 4'd15, 1'b1);
        send_command(esd_pkg::MODE_REQUEST, 4'd10, 1'b0);
        send_command(esd_pkg::MODE_REQUEST, 4'd1, 1'b1);
        send_command(esd_pkg::MODE_MOVE, 4'd0, 1'b0);
        send_command(esd_pkg::MODE_REQUEST, 4'd5, 1'b0);
        send_command(esd_pkg::MODE_REQUEST, 4'd5, 1'b0);
        // same floor pending in both sets
        send_command(esd_pkg::MODE_REQUEST, 4'd5, 1'b1);
        send_command(esd_pkg::MODE_REQUEST, 4'd9, 1'b1);
        send_command(esd_pkg::MODE_REQUEST, 4'd3, 1'b0);
        send_command(esd_pkg::MODE_MOVE, 4'd15, 1'b1);
        send_command(esd_pkg::MODE_MOVE, 4'd0, 1'b0);
        send_command(esd_pkg::MODE_MOVE, 4'd7, 1'b1);
        send_command(esd_pkg::MODE_MOVE, 4'd0, 1'b0);
        send_command(esd_pkg::MODE_MOVE, 4'd0, 1'b0);
        // trip back down to floor 1
        send_command(esd_pkg::MODE_REQUEST, 4'd1, 1'b1);
        send_command(esd_pkg::MODE_MOVE, 4'd0, 1'b0);
        send_command(esd_pkg::MODE_REQUEST, 4'd6, 1'b0);
        send_command(esd_pkg::MODE_FAIL, 4'd15, 1'b1);
        send_command(esd_pkg::MODE_REQUEST, 4'd4, 1'b0);
        send_command(esd_pkg::MODE_MOVE, 4'd0, 1'b0);
        send_command(esd_pkg::MODE_FAIL, 4'd0, 1'b0);
        send_command(esd_pkg::MODE_RESET, 4'd15, 1'b1);
        send_command(esd_pkg::MODE_REQUEST, 4'd8, 1'b1);
        send_command(esd_pkg::MODE_RESET, 4'd0, 1'b0);

        for (int phase = 0; phase < 3; phase++)
        begin
            drain_reports();
            gap_pct   = (phase == 0) ? 29 : (phase == 1) ? 74 : 0;
            stall_pct = (phase == 0) ? 74 : (phase == 1) ? 29 : 0;
            repeat (PHASE_ITEMS) send_random();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.outstanding() != 0)
            $error("%0d expected reports never arrived", sb.outstanding());
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("PASS elevator_stop_dispatcher");
        else
            $display("FAIL elevator_stop_dispatcher");
        $finish;
    end

endmodule
